// ===== hdl/assert_macros.svh =====
// Assertion macros used by the queue core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on clk_i, disabled while rst_ni is low
`define CRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define CRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  `CRQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/crq_pkg.sv =====
// Types, constants and ring index helpers for the coalescing request queue
package crq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 5;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CRQ_IDLE,
    CRQ_SCAN,
    CRQ_DEQ,
    CRQ_RESULT
  } state_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_id;
    logic [7:0]  request_volume;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_volume;
    logic [3:0]  pending_count;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  volume;
  } slot_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic logic [3:0] ring_count(idx_t head, idx_t tail);
    logic [CNT_W-1:0] diff;
    diff = CNT_W'(tail) - CNT_W'(head);
    if (tail < head) begin
      diff = diff + CNT_W'(QUEUE_DEPTH);
    end
    return diff[3:0];
  endfunction

endpackage

// ===== hdl/crq_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data
module crq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/coalescing_ring_request_queue_core.sv =====
// Coalescing ring request queue: top level with scan sequencer and output register
// Sequencing: a dequeue passes DEQ then RESULT; an empty dequeue, or an enqueue when full or
// empty, goes straight to RESULT; other enqueues run the one-entry-per-cycle match scan through the slot RAM.
// Throughput: one transaction in flight; the next is accepted once the result registers.
// Reset (async, active low) clears head, tail, sequencer and output valid;
// slot contents are undefined until appended, and no clearing pass runs.
`include "assert_macros.svh"

module coalescing_ring_request_queue_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  crq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output crq_pkg::out_t  out_data_o
);

  crq_pkg::state_e  state_q, state_d;
  crq_pkg::idx_t    head_q, head_d;
  crq_pkg::idx_t    tail_q, tail_d;
  crq_pkg::idx_t    scan_q, scan_d;
  crq_pkg::in_t     req_q, req_d;
  crq_pkg::status_e status_q, status_d;
  crq_pkg::slot_t   res_q, res_d;
  logic             out_valid_q, out_valid_d;
  crq_pkg::out_t    out_q, out_d;

  logic           in_fire;
  logic           empty;
  logic           full;
  logic           hit;
  logic           scan_last;
  logic           out_free;
  crq_pkg::idx_t  scan_next;
  crq_pkg::idx_t  raddr;
  crq_pkg::idx_t  waddr;
  logic           we;
  crq_pkg::slot_t wdata;
  crq_pkg::slot_t rdata;

  crq_ram #(
    .DEPTH(crq_pkg::QUEUE_DEPTH),
    .WIDTH($bits(crq_pkg::slot_t))
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_stall_o = (state_q != crq_pkg::CRQ_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign empty      = (head_q == tail_q);
  assign full       = (crq_pkg::ring_next(tail_q) == head_q);
  assign scan_next  = crq_pkg::ring_next(scan_q);
  assign scan_last  = (scan_next == tail_q);
  assign hit        = (rdata.id == req_q.request_id);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign raddr      = (state_q == crq_pkg::CRQ_SCAN) ? scan_next : head_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crq_pkg::CRQ_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == crq_pkg::OP_DEQUEUE) begin
            state_d = empty ? crq_pkg::CRQ_RESULT : crq_pkg::CRQ_DEQ;
          end else if (full || empty) begin
            state_d = crq_pkg::CRQ_RESULT;
          end else begin
            state_d = crq_pkg::CRQ_SCAN;
          end
        end
      end
      crq_pkg::CRQ_SCAN: begin
        if (hit || scan_last) begin
          state_d = crq_pkg::CRQ_RESULT;
        end
      end
      crq_pkg::CRQ_DEQ: begin
        state_d = crq_pkg::CRQ_RESULT;
      end
      crq_pkg::CRQ_RESULT: begin
        if (out_free) begin
          state_d = crq_pkg::CRQ_IDLE;
        end
      end
      default: state_d = crq_pkg::CRQ_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    scan_d      = scan_q;
    req_d       = req_q;
    status_d    = status_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = tail_q;
    wdata       = '{id: req_q.request_id, volume: req_q.request_volume};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      crq_pkg::CRQ_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          res_d = '0;
          scan_d = head_q;
          if (in_data_i.operation == crq_pkg::OP_DEQUEUE) begin
            status_d = crq_pkg::ST_EMPTY;
          end else if (full) begin
            status_d = crq_pkg::ST_DROPPED;
          end else if (empty) begin
            we       = 1'b1;
            wdata    = '{id: in_data_i.request_id, volume: in_data_i.request_volume};
            tail_d   = crq_pkg::ring_next(tail_q);
            status_d = crq_pkg::ST_APPENDED;
          end
        end
      end
      crq_pkg::CRQ_SCAN: begin
        if (hit) begin
          status_d = crq_pkg::ST_MERGED;
          if (req_q.request_volume > rdata.volume) begin
            we    = 1'b1;
            waddr = scan_q;
          end
        end else if (scan_last) begin
          we       = 1'b1;
          tail_d   = crq_pkg::ring_next(tail_q);
          status_d = crq_pkg::ST_APPENDED;
        end else begin
          scan_d = scan_next;
        end
      end
      crq_pkg::CRQ_DEQ: begin
        res_d    = rdata;
        head_d   = crq_pkg::ring_next(head_q);
        status_d = crq_pkg::ST_DEQUEUED;
      end
      crq_pkg::CRQ_RESULT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.out_id        = res_q.id;
          out_d.out_volume    = res_q.volume;
          out_d.pending_count = crq_pkg::ring_count(head_q, tail_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crq_pkg::CRQ_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    req_q    <= req_d;
    status_q <= status_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CRQ_ASSERT(a_head_in_range, head_q <= crq_pkg::idx_t'(crq_pkg::QUEUE_DEPTH - 1), "head out of range")
  `CRQ_ASSERT(a_tail_in_range, tail_q <= crq_pkg::idx_t'(crq_pkg::QUEUE_DEPTH - 1), "tail out of range")
  `CRQ_ASSERT_IMP(a_scan_nonempty, state_q == crq_pkg::CRQ_SCAN, head_q != tail_q, "scan on empty queue")
  `CRQ_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(state_q == crq_pkg::CRQ_RESULT), "result without sequencer")

endmodule

// ===== bench/coalescing_ring_request_queue_core_tb.sv =====
// Self-checking testbench for the coalescing ring request queue core
`timescale 1ns / 1ps

module coalescing_ring_request_queue_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ID_POOL = 20;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall_o;
  crq_pkg::in_t  in_data;
  logic          out_valid_o;
  logic          out_stall;
  crq_pkg::out_t out_data_o;

  logic [15:0] model_ids [crq_pkg::QUEUE_DEPTH];
  logic [7:0]  model_vols [crq_pkg::QUEUE_DEPTH];
  int          model_head;
  int          model_tail;

  crq_pkg::out_t predicted_replies [$];
  logic [15:0]   id_pool [ID_POOL];
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatches;
  int            requests_sent;
  int            cycle_count;
  int            status_seen [5];

  coalescing_ring_request_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int slot_after(int pos);
    return (pos + 1) % crq_pkg::QUEUE_DEPTH;
  endfunction

  function automatic crq_pkg::out_t model_queue_op(crq_pkg::in_t req);
    crq_pkg::out_t res;
    int            pos;
    bit            found;
    res = '0;
    found = 1'b0;
    if (req.operation == crq_pkg::OP_ENQUEUE) begin
      if (slot_after(model_tail) == model_head) begin
        res.status = crq_pkg::ST_DROPPED;
      end else begin
        for (pos = model_head; pos != model_tail && !found; pos = slot_after(pos)) begin
          if (model_ids[pos] == req.request_id) begin
            found = 1'b1;
            if (req.request_volume > model_vols[pos]) begin
              model_vols[pos] = req.request_volume;
            end
          end
        end
        if (found) begin
          res.status = crq_pkg::ST_MERGED;
        end else begin
          model_ids[model_tail] = req.request_id;
          model_vols[model_tail] = req.request_volume;
          model_tail = slot_after(model_tail);
          res.status = crq_pkg::ST_APPENDED;
        end
      end
    end else if (model_head == model_tail) begin
      res.status = crq_pkg::ST_EMPTY;
    end else begin
      res.out_id = model_ids[model_head];
      res.out_volume = model_vols[model_head];
      model_head = slot_after(model_head);
      res.status = crq_pkg::ST_DEQUEUED;
    end
    res.pending_count = 4'((model_tail - model_head + crq_pkg::QUEUE_DEPTH)
                           % crq_pkg::QUEUE_DEPTH);
    return res;
  endfunction

  function automatic crq_pkg::in_t make_request(logic op, logic [15:0] id, logic [7:0] vol);
    crq_pkg::in_t r;
    r.operation = op;
    r.request_id = id;
    r.request_volume = vol;
    return r;
  endfunction

  task automatic issue_request(input crq_pkg::in_t req);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted_replies.push_back(model_queue_op(req));
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_replies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    crq_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = predicted_replies.pop_front();
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data_o.status);
          mismatches++;
        end
        if (out_data_o.out_id !== want.out_id) begin
          $display("%0t: out_id expected %h actual %h", $time, want.out_id,
                   out_data_o.out_id);
          mismatches++;
        end
        if (out_data_o.out_volume !== want.out_volume) begin
          $display("%0t: out_volume expected %h actual %h", $time, want.out_volume,
                   out_data_o.out_volume);
          mismatches++;
        end
        if (out_data_o.pending_count !== want.pending_count) begin
          $display("%0t: pending_count expected %0d actual %0d", $time,
                   want.pending_count, out_data_o.pending_count);
          mismatches++;
        end
        if (want.status <= crq_pkg::ST_EMPTY) begin
          status_seen[want.status]++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time,
               predicted_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_empty_dequeue();
    issue_request(make_request(crq_pkg::OP_DEQUEUE, 16'hFFFF, 8'hFF));
  endtask

  // fill to capacity, then show that fullness wins over a matching id
  task automatic test_fill_and_overflow();
    logic [15:0] id;
    logic [7:0]  vol;
    for (int k = 0; k < crq_pkg::QUEUE_DEPTH - 1; k++) begin
      id = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(k * 4099);
      vol = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'(k * 17);
      issue_request(make_request(crq_pkg::OP_ENQUEUE, id, vol));
    end
    issue_request(make_request(crq_pkg::OP_ENQUEUE, 16'h1234, 8'h80));
    issue_request(make_request(crq_pkg::OP_ENQUEUE, 16'(2 * 4099), 8'hFF));
  endtask

  task automatic test_merge_volumes();
    issue_request(make_request(crq_pkg::OP_DEQUEUE, 16'h0000, 8'h00));
    issue_request(make_request(crq_pkg::OP_ENQUEUE, 16'(3 * 4099), 8'hF0));
    issue_request(make_request(crq_pkg::OP_ENQUEUE, 16'(4 * 4099), 8'h01));
    issue_request(make_request(crq_pkg::OP_ENQUEUE, 16'hFFFF, 8'hFF));
    issue_request(make_request(crq_pkg::OP_DEQUEUE, 16'hFFFF, 8'hFF));
  endtask

  function automatic crq_pkg::in_t random_request(int enq_pct);
    crq_pkg::in_t r;
    r.request_volume = 8'($urandom_range(255));
    r.request_id = ($urandom_range(9) == 0) ? 16'($urandom) :
                   id_pool[$urandom_range(ID_POOL - 1)];
    r.operation = ($urandom_range(99) < enq_pct) ? crq_pkg::OP_ENQUEUE : crq_pkg::OP_DEQUEUE;
    return r;
  endfunction

  // enqueue bias shifts every few dozen items so the ring swings between empty and full
  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    int enq_pct;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < ID_POOL; i++) begin
      id_pool[i] = 16'($urandom);
    end
    enq_pct = 55;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 30;
          1: enq_pct = 55;
          default: enq_pct = 85;
        endcase
      end
      issue_request(random_request(enq_pct));
    end
    hold_until_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    requests_sent = 0;
    cycle_count = 0;
    model_head = 0;
    model_tail = 0;
    send_idle_pct = 26;
    recv_idle_pct = 67;
    for (int s = 0; s < 5; s++) begin
      status_seen[s] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_fill_and_overflow();
    test_merge_volumes();
    hold_until_drained();

    test_random_traffic(700, 26, 67);
    test_random_traffic(700, 67, 26);
    test_random_traffic(600, 0, 0);

    repeat (40) @(posedge clk_i);
    if (predicted_replies.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time,
               predicted_replies.size());
      mismatches++;
    end
    $display("Checked %0d requests: %0d appended, %0d merged, %0d dropped,",
             requests_sent, status_seen[crq_pkg::ST_APPENDED],
             status_seen[crq_pkg::ST_MERGED], status_seen[crq_pkg::ST_DROPPED]);
    $display("  %0d dequeued, %0d on an empty ring, %0d mismatches",
             status_seen[crq_pkg::ST_DEQUEUED], status_seen[crq_pkg::ST_EMPTY], mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/crq_pkg.sv
hdl/crq_ram.sv
hdl/coalescing_ring_request_queue_core.sv
bench/coalescing_ring_request_queue_core_tb.sv
